>>> hdl/gqtl_pkg.sv
// ----------------------------------------------------------------------------
// gqtl_pkg
// Shared types, codes and widths for the glyph quad text layout block.
// ----------------------------------------------------------------------------
package gqtl_pkg;

   localparam int MAX_GLYPHS_DEF  = 128;
   localparam int COORD_BITS_DEF  = 32;
   localparam int WORDS_PER_GLYPH = 9;
   localparam int FIRST_CODE      = 32;
   localparam int QUEUE_DEPTH     = 4;
   localparam int ONE_Q16         = 65536;

   // scaled glyph word after the floor shift, and the widest pen sum
   localparam int SC_W  = 51;
   localparam int SUM_W = 52;

   localparam logic [7:0] CHAR_NL  = 8'h0a;
   localparam logic [7:0] CHAR_TAB = 8'h09;

   localparam logic [1:0] OP_CHAR  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_BEGIN = 2'd2;

   localparam logic [2:0] CSR_POINT_SIZE  = 3'd0;
   localparam logic [2:0] CSR_LINE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_PIX_RATIO   = 3'd2;
   localparam logic [2:0] CSR_GLYPH_COUNT = 3'd3;
   localparam logic [2:0] CSR_EMIT_TRI    = 3'd4;

   localparam logic [2:0] K_NONE    = 3'd0;
   localparam logic [2:0] K_LOAD    = 3'd1;
   localparam logic [2:0] K_BEGIN   = 3'd2;
   localparam logic [2:0] K_GLYPH   = 3'd3;
   localparam logic [2:0] K_SPACE   = 3'd4;
   localparam logic [2:0] K_NEWLINE = 3'd5;
   localparam logic [2:0] K_TAB     = 3'd6;

   localparam logic [3:0] W_ADV = 4'd0;
   localparam logic [3:0] W_X0  = 4'd1;
   localparam logic [3:0] W_Y0  = 4'd2;
   localparam logic [3:0] W_X1  = 4'd3;
   localparam logic [3:0] W_Y1  = 4'd4;
   localparam logic [3:0] W_S0  = 4'd5;
   localparam logic [3:0] W_T0  = 4'd6;
   localparam logic [3:0] W_S1  = 4'd7;
   localparam logic [3:0] W_T1  = 4'd8;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         char_code;
      logic [6:0]         glyph_slot;
      logic [3:0]         word_select;
      logic signed [31:0] word_value;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] tex_s;
      logic signed [31:0] tex_t;
      logic [31:0]        pixel_range;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         slot;
      logic [3:0]         word_sel;
      logic signed [31:0] value0;
      logic signed [31:0] value1;
   } cmd_type;

   typedef struct packed {
      logic [31:0] point_size;
      logic [31:0] line_height;
      logic [31:0] pixel_range_ratio;
      logic [7:0]  glyph_count;
      logic        emit_triangles;
   } cfg_type;

endpackage

>>> hdl/gqtl_front.sv
// ----------------------------------------------------------------------------
// gqtl_front
// Accepts input beats, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module gqtl_front import gqtl_pkg::*; #(
   parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    q_valid,
   output cmd_type q_cmd,
   input  logic    q_pop
);

   localparam int QP_W = $clog2(QUEUE_DEPTH);
   localparam logic [7:0] MAX8 = 8'(MAX_GLYPHS);

   cmd_type          q_mem_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]  wr_ptr_ff;
   logic [QP_W-1:0]  rd_ptr_ff;
   logic [QP_W:0]    count_ff;
   logic [QP_W:0]    count_in;

   cmd_type    cmd;
   logic [7:0] n_glyphs;
   logic [7:0] code_slot;
   logic       push;

   always_comb begin
      n_glyphs  = (cfg.glyph_count > MAX8) ? MAX8 : cfg.glyph_count;
      code_slot = req_data.char_code - 8'(FIRST_CODE);
      cmd.kind     = K_NONE;
      cmd.slot     = 8'd0;
      cmd.word_sel = req_data.word_select;
      cmd.value0   = req_data.word_value;
      cmd.value1   = req_data.start_y;
      case (req_data.op)
         OP_CHAR: begin
            if (req_data.char_code > 8'(FIRST_CODE)) begin
               cmd.slot = code_slot;
               if (code_slot < n_glyphs) cmd.kind = K_GLYPH;
            end else if (req_data.char_code == 8'(FIRST_CODE)) begin
               if (n_glyphs != 8'd0) cmd.kind = K_SPACE;
            end else if (req_data.char_code == CHAR_NL) begin
               cmd.kind = K_NEWLINE;
            end else if (req_data.char_code == CHAR_TAB) begin
               if (n_glyphs != 8'd0) cmd.kind = K_TAB;
            end
         end
         OP_LOAD: begin
            cmd.slot = {1'b0, req_data.glyph_slot};
            if ({1'b0, req_data.glyph_slot} < MAX8 &&
                req_data.word_select < 4'(WORDS_PER_GLYPH)) cmd.kind = K_LOAD;
         end
         OP_BEGIN: begin
            cmd.kind   = K_BEGIN;
            cmd.value0 = req_data.start_x;
         end
         default: cmd.kind = K_NONE;
      endcase
   end

   assign req_stall = (count_ff == (QP_W+1)'(QUEUE_DEPTH));
   // beats that do nothing are dropped here
   assign push      = req_valid && !req_stall && (cmd.kind != K_NONE);
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = q_mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !(q_pop && q_valid)) count_in = count_ff + 1'b1;
      else if (!push && q_pop && q_valid) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (q_pop && q_valid) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_mem_ff[wr_ptr_ff] <= cmd;
   end

endmodule

>>> hdl/gqtl_rem.sv
// ----------------------------------------------------------------------------
// gqtl_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gqtl_rem import gqtl_pkg::*; #(
   parameter int DW = COORD_BITS_DEF + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] q_ff;
   logic [DW-1:0] d_ff;
   logic [DW:0]   rem_ff;
   logic [DW:0]   trial;
   logic [DW:0]   rem_in;

   always_comb begin
      trial  = {rem_ff[DW-1:0], q_ff[DW-1]};
      rem_in = (trial >= {1'b0, d_ff}) ? trial - {1'b0, d_ff} : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         d_ff   <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DW-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[DW-1:0];

endmodule

>>> hdl/gqtl_back.sv
// ----------------------------------------------------------------------------
// gqtl_back
// Executes queued commands: glyph table, pen state, scaling and vertex output.
// ----------------------------------------------------------------------------
module gqtl_back import gqtl_pkg::*; #(
   parameter int MAX_GLYPHS = MAX_GLYPHS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int DEPTH  = MAX_GLYPHS * WORDS_PER_GLYPH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DW     = COORD_BITS + 1;
   localparam int C      = COORD_BITS;
   localparam logic signed [SUM_W-1:0] CMAX =
      SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] CMIN = -CMAX - SUM_W'(1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;
   localparam logic [2:0] ST_TAB  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;

   function automatic logic signed [C-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      if (v > CMAX) return CMAX[C-1:0];
      if (v < CMIN) return CMIN[C-1:0];
      return v[C-1:0];
   endfunction

   logic [31:0] mem [DEPTH];

   logic [2:0]  state_ff, state_in;
   logic [2:0]  kind_ff;
   logic [7:0]  slot_ff;
   logic [3:0]  rd_cnt_ff;
   logic        rd_en, rd_end, mem_we;
   logic [ADDR_W-1:0] rd_addr, wr_addr;

   // read and scale pipeline
   logic signed [31:0] rd_data_ff;
   logic               p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic [3:0]         p1_tag_ff, p2_tag_ff, p3_tag_ff;
   logic               p1_end_ff, p2_end_ff, p3_end_ff;
   logic [63:0]        prod_ff;
   logic               p2_neg_ff;
   logic signed [31:0] p2_raw_ff, p3_raw_ff;
   logic signed [SC_W-1:0] sc_ff;
   logic [31:0]        mag;
   logic signed [64:0] sp;
   logic signed [64:0] sp_sh;

   logic signed [C-1:0] pen_x_ff, pen_y_ff, margin_ff, pen_nx_ff, tw_ff;
   logic signed [C-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [31:0]  s0_ff, t0_ff, s1_ff, t1_ff;

   logic signed [C-1:0]     base4;
   logic signed [C-1:0]     sat4;
   logic signed [32:0]      tdiff;
   logic signed [31:0]      t_sat;

   logic [63:0] pr_prod_ff, spc_prod_ff;
   logic [31:0] pr_ff;

   logic signed [SUM_W-1:0] diff;
   logic                    diff_neg;
   logic [DW-1:0]           div_dividend, div_divisor, div_rem;
   logic                    div_start, div_done;
   logic signed [SUM_W-1:0] rem_s;
   logic signed [C-1:0]     tab_pen;
   logic signed [C-1:0]     begin_x, begin_y, nl_y;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     vtx_out;
   logic [2:0]  vtx_ff;
   logic        vtx_last, emit_go;

   // free-running products of configuration registers
   always_ff @(posedge clock) begin
      pr_prod_ff  <= 64'(cfg.point_size) * 64'(cfg.pixel_range_ratio);
      spc_prod_ff <= 64'(cfg.line_height) * 64'(cfg.point_size);
      pr_ff       <= (pr_prod_ff[63:48] != 16'd0) ? 32'hffff_ffff : pr_prod_ff[47:16];
   end

   assign q_pop   = (state_ff == ST_IDLE) && q_valid;
   assign mem_we  = q_pop && (q_cmd.kind == K_LOAD);
   assign wr_addr = (ADDR_W'(q_cmd.slot) << 3) + ADDR_W'(q_cmd.slot) +
                    ADDR_W'(q_cmd.word_sel);
   assign rd_en   = (state_ff == ST_READ);
   assign rd_addr = (ADDR_W'(slot_ff) << 3) + ADDR_W'(slot_ff) + ADDR_W'(rd_cnt_ff);
   assign rd_end  = (rd_cnt_ff == ((kind_ff == K_GLYPH) ? W_T1 : W_ADV));

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= q_cmd.value0;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // floor of word * point_size, shift 14 for the tab stop width
   always_comb begin
      mag   = rd_data_ff[31] ? 32'(-rd_data_ff) : 32'(rd_data_ff);
      sp    = p2_neg_ff ? -$signed({1'b0, prod_ff}) : $signed({1'b0, prod_ff});
      sp_sh = (kind_ff == K_TAB) ? (sp >>> 14) : (sp >>> 16);
   end

   always_comb begin
      case (p3_tag_ff)
         W_ADV, W_X0, W_X1: base4 = (kind_ff == K_TAB) ? '0 : pen_x_ff;
         W_Y0, W_Y1:        base4 = pen_y_ff;
         default:           base4 = '0;
      endcase
      sat4  = sat_coord(SUM_W'(base4) + SUM_W'(sc_ff));
      tdiff = 33'sd65536 - 33'(p3_raw_ff);
      if (tdiff > 33'sd2147483647) t_sat = 32'sh7fff_ffff;
      else if (tdiff < -33'sd2147483648) t_sat = 32'sh8000_0000;
      else t_sat = tdiff[31:0];
   end

   // tab: remainder of the distance from the margin by the stop width
   always_comb begin
      diff         = SUM_W'(pen_x_ff) - SUM_W'(margin_ff);
      diff_neg     = diff[SUM_W-1];
      div_dividend = diff_neg ? DW'(-diff) : DW'(diff);
      div_divisor  = tw_ff[C-1] ? -DW'(tw_ff) : DW'(tw_ff);
      div_start    = (state_ff == ST_TAB) && (tw_ff != '0);
      rem_s        = diff_neg ? -SUM_W'(div_rem) : SUM_W'(div_rem);
      tab_pen      = sat_coord(SUM_W'(pen_x_ff) + SUM_W'(tw_ff) - rem_s);
      begin_x      = sat_coord(SUM_W'(q_cmd.value0));
      begin_y      = sat_coord(SUM_W'(q_cmd.value1));
      nl_y         = sat_coord(SUM_W'(pen_y_ff) - SUM_W'({1'b0, spc_prod_ff[63:16]}));
   end

   gqtl_rem #(.DW(DW)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      vtx_last = cfg.emit_triangles ? (vtx_ff == 3'd5) : (vtx_ff == 3'd3);
      emit_go  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
      vtx_out.pixel_range = pr_ff;
      vtx_out.last        = vtx_last;
      vtx_out.tex_s = s0_ff;
      vtx_out.tex_t = t0_ff;
      vtx_out.pos_x = 32'(x0_ff);
      vtx_out.pos_y = 32'(y0_ff);
      case (vtx_ff)
         3'd1: begin
            vtx_out.tex_s = s1_ff;
            vtx_out.pos_x = 32'(x1_ff);
         end
         3'd2: begin
            vtx_out.tex_s = s1_ff;
            vtx_out.tex_t = t1_ff;
            vtx_out.pos_x = 32'(x1_ff);
            vtx_out.pos_y = 32'(y1_ff);
         end
         3'd3: begin
            vtx_out.tex_t = t1_ff;
            vtx_out.pos_y = 32'(y1_ff);
            if (cfg.emit_triangles) begin
               vtx_out.tex_s = s1_ff;
               vtx_out.pos_x = 32'(x1_ff);
            end
         end
         3'd4: begin
            vtx_out.tex_t = t1_ff;
            vtx_out.pos_y = 32'(y1_ff);
         end
         default: vtx_out.tex_s = s0_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && (q_cmd.kind == K_GLYPH || q_cmd.kind == K_SPACE ||
                            q_cmd.kind == K_TAB)) state_in = ST_READ;
         end
         ST_READ: if (rd_end) state_in = ST_WAIT;
         ST_WAIT: begin
            if (p3_vld_ff && p3_end_ff) begin
               if (kind_ff == K_GLYPH) state_in = ST_EMIT;
               else if (kind_ff == K_TAB) state_in = ST_TAB;
               else state_in = ST_IDLE;
            end
         end
         ST_EMIT: if (emit_go && vtx_last) state_in = ST_IDLE;
         ST_TAB:  state_in = (tw_ff == '0) ? ST_IDLE : ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         rd_cnt_ff    <= '0;
         vtx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         margin_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         p1_vld_ff <= rd_en;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
            vtx_ff       <= vtx_last ? 3'd0 : vtx_ff + 3'd1;
            if (vtx_last) pen_x_ff <= pen_nx_ff;
         end
         if (q_pop) rd_cnt_ff <= '0;
         else if (rd_en) rd_cnt_ff <= rd_cnt_ff + 4'd1;
         if (q_pop && q_cmd.kind == K_BEGIN) begin
            pen_x_ff  <= begin_x;
            pen_y_ff  <= begin_y;
            margin_ff <= begin_x;
         end
         if (q_pop && q_cmd.kind == K_NEWLINE) begin
            pen_x_ff <= margin_ff;
            pen_y_ff <= nl_y;
         end
         if (p3_vld_ff && kind_ff == K_SPACE) pen_x_ff <= sat4;
         if (state_ff == ST_DIV && div_done) pen_x_ff <= tab_pen;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff <= q_cmd.kind;
         slot_ff <= q_cmd.slot;
      end
      p1_tag_ff <= rd_cnt_ff;
      p1_end_ff <= rd_end;
      prod_ff   <= 64'(mag) * 64'(cfg.point_size);
      p2_neg_ff <= rd_data_ff[31];
      p2_raw_ff <= rd_data_ff;
      p2_tag_ff <= p1_tag_ff;
      p2_end_ff <= p1_end_ff;
      sc_ff     <= SC_W'(sp_sh);
      p3_raw_ff <= p2_raw_ff;
      p3_tag_ff <= p2_tag_ff;
      p3_end_ff <= p2_end_ff;
      if (p3_vld_ff) begin
         case (p3_tag_ff)
            W_ADV:   begin
               pen_nx_ff <= sat4;
               tw_ff     <= sat4;
            end
            W_X0:    x0_ff <= sat4;
            W_Y0:    y0_ff <= sat4;
            W_X1:    x1_ff <= sat4;
            W_Y1:    y1_ff <= sat4;
            W_S0:    s0_ff <= p3_raw_ff;
            W_T0:    t0_ff <= t_sat;
            W_S1:    s1_ff <= p3_raw_ff;
            W_T1:    t1_ff <= t_sat;
            default: s0_ff <= s0_ff;
         endcase
      end
      if (emit_go) rsp_data_ff <= vtx_out;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/glyph_quad_text_layout.sv
// ----------------------------------------------------------------------------
// glyph_quad_text_layout
// Text layout into textured glyph quads in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A printable character is popped from the queue, its nine glyph table words
// are read one per cycle and pass through the read and scale pipeline (table
// read, multiply, shift, saturate) around one 32x32 multiplier, and then 4 or 6
// vertex beats leave at one per cycle when the output is not stalled. A space
// reads only the advance word; a tab reads it too and, for a nonzero stop width,
// runs the remainder unit at one quotient bit per cycle; a glyph load, begin or
// newline is done as it is popped, without leaving the idle state. A four-entry
// command queue sits between the input and the execution side, so input beats
// keep being taken, until the queue is full, while a glyph is laid out or a
// vertex waits on the output register. The glyph table is undefined after reset
// and must be loaded before use.
module glyph_quad_text_layout import gqtl_pkg::*; #(
   parameter int MAX_GLYPHS = MAX_GLYPHS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.point_size        <= 32'(ONE_Q16);
         cfg_ff.line_height       <= 32'(ONE_Q16);
         cfg_ff.pixel_range_ratio <= 32'(ONE_Q16);
         cfg_ff.glyph_count       <= 8'd0;
         cfg_ff.emit_triangles    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POINT_SIZE:  cfg_ff.point_size        <= csr_wdata;
            CSR_LINE_HEIGHT: cfg_ff.line_height       <= csr_wdata;
            CSR_PIX_RATIO:   cfg_ff.pixel_range_ratio <= csr_wdata;
            CSR_GLYPH_COUNT: cfg_ff.glyph_count       <= csr_wdata[7:0];
            CSR_EMIT_TRI:    cfg_ff.emit_triangles    <= csr_wdata[0];
            default:         cfg_ff.glyph_count       <= cfg_ff.glyph_count;
         endcase
      end
   end

   gqtl_front #(.MAX_GLYPHS(MAX_GLYPHS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop)
   );

   gqtl_back #(.MAX_GLYPHS(MAX_GLYPHS), .COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
